@@ hw/rtl/svn_pkg.sv @@
`default_nettype none

package svn_pkg;

   // Default width of one input component (two's complement Q16.16).
   localparam int COMPONENT_WIDTH_DEF = 32;

   // Result format.
   localparam int OUT_WIDTH  = 32;
   localparam int FRAC_BITS  = 30;
   localparam int QUOT_WIDTH = FRAC_BITS + 1;

   // Configuration register layout.
   localparam int THR_WIDTH = 31;
   localparam int CNT_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 31;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_THRESHOLD_LENGTH = 1'b0,
      CSR_COMPONENT_COUNT  = 1'b1
   } csr_index_type;

   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(66);
   localparam logic [CNT_WIDTH-1:0] CNT_RESET = CNT_WIDTH'(3);
   localparam logic [CNT_WIDTH-1:0] CNT_MIN   = CNT_WIDTH'(2);
   localparam logic [CNT_WIDTH-1:0] CNT_MID   = CNT_WIDTH'(3);
   localparam logic [CNT_WIDTH-1:0] CNT_MAX   = CNT_WIDTH'(4);

   // 1.0 in Q1.30.
   localparam logic signed [OUT_WIDTH-1:0] ONE_Q130 = OUT_WIDTH'(32'h4000_0000);
   localparam logic [OUT_WIDTH-1:0] LEN_SAT = {OUT_WIDTH{1'b1}};

   // Signed Q1.30 result from a quotient magnitude and a sign.
   function automatic logic signed [OUT_WIDTH-1:0] apply_sign(
      input logic [QUOT_WIDTH-1:0] q,
      input logic                  neg
   );
      logic signed [OUT_WIDTH-1:0] v;
      begin
         v = signed'(OUT_WIDTH'(q));
         return neg ? -v : v;
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/safe_vector_normalize.sv @@
// Vector normalization with a length threshold.
//
// The request channel (req_*) takes one vector of four signed Q16.16
// components per word. The response channel (rsp_*) returns one word per
// request, in order: the Q1.30 unit vector, the Q16.16 length and a flag
// that is set when the length is zero or below the threshold, in which case
// unit X and a length of zero are returned. Unused components read as zero
// (z) or pass through (w).
// The csr_* port writes the threshold (index 0) and the component count
// (index 1); write only while no word is in flight.
// The pipeline has input, square and sum stages, one stage per root bit
// of the square root, one stage per quotient bit of the four dividers and
// a formatting stage.
// Throughput is one word per cycle. When the receiver holds rsp_ready low
// with a word waiting, the whole pipeline holds and req_ready drops; no word
// is lost or repeated. Reset empties the pipeline and loads the register
// defaults (threshold 66, three components).

`default_nettype none

module safe_vector_normalize #(
   parameter int COMPONENT_WIDTH = svn_pkg::COMPONENT_WIDTH_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire  signed [COMPONENT_WIDTH-1:0]       req_comp_x,
   input  wire  signed [COMPONENT_WIDTH-1:0]       req_comp_y,
   input  wire  signed [COMPONENT_WIDTH-1:0]       req_comp_z,
   input  wire  signed [COMPONENT_WIDTH-1:0]       req_comp_w,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [svn_pkg::OUT_WIDTH-1:0]    rsp_unit_x,
   output logic signed [svn_pkg::OUT_WIDTH-1:0]    rsp_unit_y,
   output logic signed [svn_pkg::OUT_WIDTH-1:0]    rsp_unit_z,
   output logic signed [svn_pkg::OUT_WIDTH-1:0]    rsp_unit_w,
   output logic        [svn_pkg::OUT_WIDTH-1:0]    rsp_vector_length,
   output logic                                    rsp_below_threshold,
   input  wire                                     csr_wr_en,
   input  wire         [svn_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire         [svn_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int W    = COMPONENT_WIDTH;
   localparam int SW   = 2 * W + 2;           // sum of four squares
   localparam int LW   = W + 1;               // root width
   localparam int RW   = W + 4;               // root remainder width
   localparam int DW   = LW + 1;              // divider remainder width
   localparam int QW   = svn_pkg::QUOT_WIDTH;
   localparam int OW   = svn_pkg::OUT_WIDTH;
   localparam int CMPW = (LW > svn_pkg::THR_WIDTH) ? LW : svn_pkg::THR_WIDTH;
   localparam int LXW  = (LW > OW) ? LW : OW;
   localparam int SQ0  = 3;                   // first root stage
   localparam int D0   = SQ0 + LW;            // decision and first quotient bit
   localparam int OUTS = D0 + QW;             // formatting stage
   localparam int NS   = OUTS + 1;

   typedef struct packed {
      logic                    vld;
      logic [3:0][W-1:0]       mag;
      logic [3:0]              neg;
      logic signed [OW-1:0]    w_pass;
      logic [3:0][2*W-1:0]     sq;
      logic [SW-1:0]           sacc;
      logic [RW-1:0]           rem;
      logic [LW-1:0]           root;
      logic                    fb;
      logic [3:0][DW-1:0]      dr;
      logic [3:0][QW-1:0]      q;
      logic signed [OW-1:0]    ux;
      logic signed [OW-1:0]    uy;
      logic signed [OW-1:0]    uz;
      logic signed [OW-1:0]    uw;
      logic [OW-1:0]           len;
   } stage_type;

   // Configuration registers.
   logic [svn_pkg::THR_WIDTH-1:0] thr_ff;
   logic [svn_pkg::CNT_WIDTH-1:0] cnt_ff;
   logic [svn_pkg::CNT_WIDTH-1:0] ncnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= svn_pkg::THR_RESET;
         cnt_ff <= svn_pkg::CNT_RESET;
      end else if (csr_wr_en) begin
         case (svn_pkg::csr_index_type'(csr_index))
            svn_pkg::CSR_THRESHOLD_LENGTH: thr_ff <= csr_wr_data[svn_pkg::THR_WIDTH-1:0];
            svn_pkg::CSR_COMPONENT_COUNT:  cnt_ff <= csr_wr_data[svn_pkg::CNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Component count clamped to two through four.
   always_comb begin
      if (cnt_ff < svn_pkg::CNT_MIN) begin
         ncnt = svn_pkg::CNT_MIN;
      end else if (cnt_ff > svn_pkg::CNT_MAX) begin
         ncnt = svn_pkg::CNT_MAX;
      end else begin
         ncnt = cnt_ff;
      end
   end

   stage_type pipe_ff [NS];
   stage_type pipe_in [NS];
   logic      adv;

   // The pipeline moves as a whole unless the last word is stalled.
   assign adv       = !pipe_ff[NS-1].vld || rsp_ready;
   assign req_ready = adv;

   // Next value of every stage.
   always_comb begin
      logic [W-1:0]    raw [4];
      logic [SW-1:0]   s;
      logic [RW-1:0]   rsh;
      logic [RW-1:0]   trial;
      logic [DW-1:0]   dsh;
      logic [DW-1:0]   dlen;
      logic [CMPW-1:0] rootc;
      logic [CMPW-1:0] thrc;
      logic [LXW-1:0]  rootx;
      logic            qb;
      raw[0] = req_comp_x;
      raw[1] = req_comp_y;
      raw[2] = req_comp_z;
      raw[3] = req_comp_w;
      s      = '0;
      rsh    = '0;
      trial  = '0;
      dsh    = '0;
      dlen   = '0;
      rootc  = '0;
      thrc   = '0;
      rootx  = '0;
      qb     = 1'b0;

      // Input stage: magnitudes and signs.
      pipe_in[0]        = pipe_ff[0];
      pipe_in[0].vld    = req_valid;
      pipe_in[0].w_pass = OW'(req_comp_w);
      for (int l = 0; l < 4; l++) begin
         pipe_in[0].neg[l] = raw[l][W-1];
         pipe_in[0].mag[l] = raw[l][W-1] ? (~raw[l] + W'(1)) : raw[l];
      end

      for (int k = 1; k < NS; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         if (k == 1) begin
            // Squares of the magnitudes.
            for (int l = 0; l < 4; l++) begin
               pipe_in[k].sq[l] = pipe_ff[k-1].mag[l] * pipe_ff[k-1].mag[l];
            end
         end else if (k == 2) begin
            // Sum over the used components.
            s = SW'(pipe_ff[k-1].sq[0]) + SW'(pipe_ff[k-1].sq[1]);
            if (ncnt >= svn_pkg::CNT_MID) begin
               s = s + SW'(pipe_ff[k-1].sq[2]);
            end
            if (ncnt == svn_pkg::CNT_MAX) begin
               s = s + SW'(pipe_ff[k-1].sq[3]);
            end
            pipe_in[k].sacc = s;
            pipe_in[k].rem  = '0;
            pipe_in[k].root = '0;
         end else if (k >= SQ0 && k < D0) begin
            // One root bit per stage, two radicand bits brought down.
            rsh   = RW'({pipe_ff[k-1].rem, pipe_ff[k-1].sacc[SW-1 -: 2]});
            trial = RW'({pipe_ff[k-1].root, 2'b01});
            pipe_in[k].sacc = pipe_ff[k-1].sacc << 2;
            if (rsh >= trial) begin
               pipe_in[k].rem  = rsh - trial;
               pipe_in[k].root = LW'({pipe_ff[k-1].root, 1'b1});
            end else begin
               pipe_in[k].rem  = rsh;
               pipe_in[k].root = LW'({pipe_ff[k-1].root, 1'b0});
            end
         end else if (k == D0) begin
            // Threshold decision and integer quotient bit.
            rootc = CMPW'(pipe_ff[k-1].root);
            thrc  = CMPW'(thr_ff);
            pipe_in[k].fb = (pipe_ff[k-1].root == '0) || (rootc < thrc);
            dlen = DW'(pipe_ff[k-1].root);
            for (int l = 0; l < 4; l++) begin
               dsh = DW'(pipe_ff[k-1].mag[l]);
               qb  = dsh >= dlen;
               pipe_in[k].dr[l] = qb ? dsh - dlen : dsh;
               pipe_in[k].q[l]  = QW'(qb);
            end
         end else if (k > D0 && k < OUTS) begin
            // One fraction bit per stage in each lane.
            dlen = DW'(pipe_ff[k-1].root);
            for (int l = 0; l < 4; l++) begin
               dsh = pipe_ff[k-1].dr[l] << 1;
               qb  = dsh >= dlen;
               pipe_in[k].dr[l] = qb ? dsh - dlen : dsh;
               pipe_in[k].q[l]  = {pipe_ff[k-1].q[l][QW-2:0], qb};
            end
         end else if (k == OUTS) begin
            // Result formatting and fallback.
            rootx = LXW'(pipe_ff[k-1].root);
            if (pipe_ff[k-1].fb) begin
               pipe_in[k].ux  = svn_pkg::ONE_Q130;
               pipe_in[k].uy  = '0;
               pipe_in[k].uz  = '0;
               pipe_in[k].uw  = (ncnt == svn_pkg::CNT_MAX) ? '0 : pipe_ff[k-1].w_pass;
               pipe_in[k].len = '0;
            end else begin
               pipe_in[k].ux = svn_pkg::apply_sign(pipe_ff[k-1].q[0], pipe_ff[k-1].neg[0]);
               pipe_in[k].uy = svn_pkg::apply_sign(pipe_ff[k-1].q[1], pipe_ff[k-1].neg[1]);
               pipe_in[k].uz = (ncnt >= svn_pkg::CNT_MID) ?
                  svn_pkg::apply_sign(pipe_ff[k-1].q[2], pipe_ff[k-1].neg[2]) : '0;
               pipe_in[k].uw = (ncnt == svn_pkg::CNT_MAX) ?
                  svn_pkg::apply_sign(pipe_ff[k-1].q[3], pipe_ff[k-1].neg[3]) :
                  pipe_ff[k-1].w_pass;
               pipe_in[k].len = (rootx > LXW'(svn_pkg::LEN_SAT)) ?
                  svn_pkg::LEN_SAT : rootx[OW-1:0];
            end
         end
      end
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (reset) begin
            pipe_ff[k].vld <= 1'b0;
         end else if (adv) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_valid           = pipe_ff[NS-1].vld;
   assign rsp_unit_x          = pipe_ff[NS-1].ux;
   assign rsp_unit_y          = pipe_ff[NS-1].uy;
   assign rsp_unit_z          = pipe_ff[NS-1].uz;
   assign rsp_unit_w          = pipe_ff[NS-1].uw;
   assign rsp_vector_length   = pipe_ff[NS-1].len;
   assign rsp_below_threshold = pipe_ff[NS-1].fb;

   // A fallback word always carries a zero length and unit X.
   a_fallback_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_below_threshold |->
         rsp_vector_length == '0 && rsp_unit_x == svn_pkg::ONE_Q130)
      else $error("fallback word malformed");

   // A normalized x never exceeds one in magnitude.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_below_threshold |->
         rsp_unit_x <= svn_pkg::ONE_Q130 && rsp_unit_x >= -svn_pkg::ONE_Q130)
      else $error("normalized x out of range");

   // A stalled word holds and the input side is closed.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready ##1
         rsp_valid && $stable(rsp_vector_length) && $stable(rsp_unit_y))
      else $error("stalled word changed");

endmodule

`default_nettype wire
